[rtl/sld_pkg.sv]
package sld_pkg;

  // Result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ZLEN    = 2'd2;

  // Register map
  localparam int          CFG_ADDR_W     = 3;
  localparam int          CFG_DATA_W     = 32;
  localparam logic        REG_SYNC_HIGH  = 1'b0;
  localparam logic        REG_SYNC_LOW   = 1'b1;
  localparam logic [7:0]  SYNC_HIGH_RST  = 8'hAA;
  localparam logic [7:0]  SYNC_LOW_RST   = 8'h55;

  // Descriptor split
  localparam int ORDER_SHIFT = 5;
  localparam logic [7:0] ADDR_MASK = 8'h1F;

  typedef struct packed {
    logic [7:0] high;
    logic [7:0] low;
  } sld_sync_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] order_code;
    logic [4:0] node_address;
    logic [7:0] payload_count;
    logic [7:0] data_byte;
    logic       last;
  } sld_result_t;

endpackage

[rtl/sld_if.sv]
// Byte request channel
interface sld_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// Parsed result channel
interface sld_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] order_code;
  logic [4:0] node_address;
  logic [7:0] payload_count;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output kind, output order_code, output node_address,
                  output payload_count, output data_byte, output last, input ready);
  modport sink   (input valid, input kind, input order_code, input node_address,
                  input payload_count, input data_byte, input last, output ready);
endinterface

[rtl/sld_cfg.sv]
module sld_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sld_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sld_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sld_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output sld_pkg::sld_sync_t             sync
);
  import sld_pkg::*;

  logic [7:0] sync_high_r;
  logic [7:0] sync_low_r;
  logic       wr_en;
  logic       reg_sel;

  // word addressed: bit 2 picks the register
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_high_r <= SYNC_HIGH_RST;
      sync_low_r  <= SYNC_LOW_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_SYNC_HIGH: sync_high_r <= pwdata[7:0];
        REG_SYNC_LOW:  sync_low_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_SYNC_HIGH: prdata[7:0] = sync_high_r;
      REG_SYNC_LOW:  prdata[7:0] = sync_low_r;
      default: ;
    endcase
  end

  assign sync.high = sync_high_r;
  assign sync.low  = sync_low_r;
endmodule

[rtl/sld_parse.sv]
module sld_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           byte_in,
  input  sld_pkg::sld_sync_t   sync,
  output logic                 res_vld,
  output sld_pkg::sld_result_t res
);
  import sld_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT_H = 3'd0,
    PH_HUNT_L = 3'd1,
    PH_LEN    = 3'd2,
    PH_DESC   = 3'd3,
    PH_DATA   = 3'd4
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] left_dec;

  assign left_dec = (left_r != 8'd0) ? left_r - 8'd1 : 8'd0;

  // per-byte decode
  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    res_vld   = 1'b0;
    res       = '0;
    unique case (phase_r)
      PH_HUNT_L: begin
        if (byte_in == sync.low)       phase_nxt = PH_LEN;
        else if (byte_in == sync.high) phase_nxt = PH_HUNT_L;
        else                           phase_nxt = PH_HUNT_H;
      end
      PH_LEN: begin
        if (byte_in == 8'd0) begin
          phase_nxt = PH_HUNT_H;
          left_nxt  = 8'd0;
          res_vld   = 1'b1;
          res.kind  = KIND_ZLEN;
          res.last  = 1'b1;
        end else begin
          left_nxt  = byte_in - 8'd1;
          phase_nxt = PH_DESC;
        end
      end
      PH_DESC: begin
        res_vld            = 1'b1;
        res.kind           = KIND_HEADER;
        res.order_code     = 3'(byte_in >> ORDER_SHIFT);
        res.node_address   = 5'(byte_in & ADDR_MASK);
        res.payload_count  = left_r;
        res.last           = (left_r == 8'd0);
        phase_nxt          = (left_r == 8'd0) ? PH_HUNT_H : PH_DATA;
      end
      PH_DATA: begin
        left_nxt      = left_dec;
        res_vld       = 1'b1;
        res.kind      = KIND_PAYLOAD;
        res.data_byte = byte_in;
        res.last      = (left_dec == 8'd0);
        if (left_dec == 8'd0) phase_nxt = PH_HUNT_H;
      end
      default: begin
        phase_nxt = (byte_in == sync.high) ? PH_HUNT_L : PH_HUNT_H;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT_H;
      left_r  <= 8'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end
endmodule

[rtl/sync_length_frame_deframer.sv]
// Channel   Direction  Payload
// in_bus    sink       in_byte[7:0]
// out_bus   source     kind, order_code, node_address, payload_count, data_byte, last
// cfg_*     APB slave  sync_high at 0x0, sync_low at 0x4
//
// One byte per cycle sustained while results are taken; a byte passes through
// the input register, then the result register, on its way to a result.
// Synchronous active-low reset returns the hunt to the first sync byte.
// A stalled result holds the result register; the input register keeps filling
// while it is empty or the result register is empty or being taken.
module sync_length_frame_deframer (
  input  logic                           clk,
  input  logic                           rst_n,
  sld_byte_if.sink                       in_bus,
  sld_result_if.source                   out_bus,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [sld_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [sld_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [sld_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import sld_pkg::*;

  sld_sync_t   sync;
  logic        s1_vld_r;
  logic [7:0]  s1_byte_r;
  logic        s1_adv;
  logic        res_vld;
  sld_result_t res;
  logic        out_vld_r;
  sld_result_t out_r;

  sld_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .sync    (sync)
  );

  // input stage moves on when the result register can take a request
  assign s1_adv       = !out_vld_r || out_bus.ready;
  assign in_bus.ready = !s1_vld_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_vld_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) s1_byte_r <= in_bus.in_byte;
  end

  sld_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_vld_r && s1_adv),
    .byte_in (s1_byte_r),
    .sync    (sync),
    .res_vld (res_vld),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= s1_vld_r && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_vld_r && res_vld) out_r <= res;
  end

  assign out_bus.valid         = out_vld_r;
  assign out_bus.kind          = out_r.kind;
  assign out_bus.order_code    = out_r.order_code;
  assign out_bus.node_address  = out_r.node_address;
  assign out_bus.payload_count = out_r.payload_count;
  assign out_bus.data_byte     = out_r.data_byte;
  assign out_bus.last          = out_r.last;
endmodule

[bench/sync_length_frame_deframer_test.sv]
module sync_length_frame_deframer_test;
  import sld_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int PHASE_BUDGET = 300;
  localparam int NUM_PHASES = 5;

  // Parser position within the byte stream
  typedef enum logic [2:0] {
    HUNT_HIGH       = 3'd0,
    HUNT_LOW        = 3'd1,
    TAKE_LENGTH     = 3'd2,
    TAKE_DESCRIPTOR = 3'd3,
    TAKE_PAYLOAD    = 3'd4
  } deframe_phase_t;

  // Tracks the parser state and holds the results still owed by the block
  class frame_scoreboard;
    logic [7:0]     sync_high;
    logic [7:0]     sync_low;
    deframe_phase_t phase;
    logic [7:0]     bytes_left;
    sld_result_t    pending[$];
    int             errors;

    function void reset_state();
      sync_high  = SYNC_HIGH_RST;
      sync_low   = SYNC_LOW_RST;
      phase      = HUNT_HIGH;
      bytes_left = '0;
      pending.delete();
    endfunction

    function void set_register(logic reg_sel, logic [7:0] value);
      if (reg_sel == REG_SYNC_HIGH) begin
        sync_high = value;
      end else begin
        sync_low = value;
      end
    endfunction

    function void report(string what);
      errors++;
      $display("mismatch: %s", what);
    endfunction

    // Advance the parser by one accepted byte
    function void note_byte(logic [7:0] b);
      sld_result_t r;
      bit          emits;
      r = '0;
      emits = 1'b0;
      case (phase)
        HUNT_LOW: begin
          if (b == sync_low) begin
            phase = TAKE_LENGTH;
          end else if (b == sync_high) begin
            phase = HUNT_LOW;
          end else begin
            phase = HUNT_HIGH;
          end
        end
        TAKE_LENGTH: begin
          if (b == 8'd0) begin
            phase = HUNT_HIGH;
            bytes_left = '0;
            r.kind = KIND_ZLEN;
            r.last = 1'b1;
            emits = 1'b1;
          end else begin
            bytes_left = b - 8'd1;
            phase = TAKE_DESCRIPTOR;
          end
        end
        TAKE_DESCRIPTOR: begin
          r.kind = KIND_HEADER;
          r.order_code = 3'(b >> ORDER_SHIFT);
          r.node_address = 5'(b & ADDR_MASK);
          r.payload_count = bytes_left;
          r.last = (bytes_left == 8'd0);
          emits = 1'b1;
          phase = (bytes_left == 8'd0) ? HUNT_HIGH : TAKE_PAYLOAD;
        end
        TAKE_PAYLOAD: begin
          if (bytes_left != 8'd0) bytes_left = bytes_left - 8'd1;
          r.kind = KIND_PAYLOAD;
          r.data_byte = b;
          r.last = (bytes_left == 8'd0);
          emits = 1'b1;
          if (bytes_left == 8'd0) phase = HUNT_HIGH;
        end
        default: begin
          phase = (b == sync_high) ? HUNT_LOW : HUNT_HIGH;
        end
      endcase
      if (emits) pending.push_back(r);
    endfunction

    function void check_field(string name, int got, int want);
      if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
    endfunction

    // Compare one accepted result with the oldest one owed
    function void check_result(sld_result_t got);
      sld_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result kind %0d", got.kind));
      end else begin
        want = pending.pop_front();
        check_field("kind", got.kind, want.kind);
        check_field("order_code", got.order_code, want.order_code);
        check_field("node_address", got.node_address, want.node_address);
        check_field("payload_count", got.payload_count, want.payload_count);
        check_field("data_byte", got.data_byte, want.data_byte);
        check_field("last", got.last, want.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  sld_byte_if   in_bus ();
  sld_result_if out_bus ();

  frame_scoreboard sb = new();
  bit steady = 1'b0;
  int hold_cycles = 0;
  int quiet = 0;

  sync_length_frame_deframer uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .out_bus     (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  function int draw_gap();
    return steady ? 0 : $urandom_range(0, 3);
  endfunction

  // Offer one byte; valid stays high when the next request follows at once
  task send_byte(input logic [7:0] value);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.in_byte <= value;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_byte(value);
  endtask

  task cfg_write(input logic reg_sel, input logic [7:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_sel, 2'b00};
    cfg_pwdata <= {24'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.set_register(reg_sel, value);
  endtask

  // Let owed results drain, then cover bytes still in flight
  task settle();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly well-formed frames with random content, some noise and broken starts
  task run_random(input int budget);
    int counted;
    int pick;
    int len;
    counted = 0;
    while (counted < budget) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (pick == 1) begin
        send_byte(sb.sync_high);
        send_byte(8'($urandom_range(0, 255)));
        counted += 2;
      end else if (pick == 2) begin
        send_byte(sb.sync_high);
        send_byte(sb.sync_low);
        send_byte(8'd0);
        counted += 3;
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          send_byte(sb.sync_high);
          counted++;
        end
        send_byte(sb.sync_high);
        send_byte(sb.sync_low);
        len = ($urandom_range(0, 24) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 8);
        send_byte(8'(len));
        send_byte(8'($urandom_range(0, 255)));
        for (int i = 1; i < len; i++) send_byte(8'($urandom_range(0, 255)));
        counted += len + 3;
      end
    end
    in_bus.valid <= 1'b0;
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin
    sld_result_t got;
    int stall;
    out_bus.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles != 0) begin
        out_bus.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        stall = draw_gap();
        if (stall != 0) begin
          out_bus.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      got.kind = out_bus.kind;
      got.order_code = out_bus.order_code;
      got.node_address = out_bus.node_address;
      got.payload_count = out_bus.payload_count;
      got.data_byte = out_bus.data_byte;
      got.last = out_bus.last;
      sb.check_result(got);
    end
  end

  // Watchdog on cycles with no request moving on either channel
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("sync_length_frame_deframer_test: errors");
      $finish;
    end
  end

  initial begin
    logic [7:0] opening[$];
    int waited;
    in_bus.valid <= 1'b0;
    in_bus.in_byte <= 8'd0;
    sb.reset_state();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Length one, zero length, repeated high sync with byte extremes,
    // broken start, sync bytes inside a frame
    opening = '{8'hAA, 8'h55, 8'h01, 8'hE0,
                8'hAA, 8'h55, 8'h00,
                8'hAA, 8'hAA, 8'h55, 8'h03, 8'h1F, 8'h00, 8'hFF,
                8'h12, 8'hAA, 8'h13,
                8'hAA, 8'h55, 8'h02, 8'hAA, 8'h55};
    foreach (opening[i]) send_byte(opening[i]);
    in_bus.valid <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        1: begin
          cfg_write(REG_SYNC_HIGH, 8'h00);
          cfg_write(REG_SYNC_LOW, 8'hFF);
        end
        2: begin
          cfg_write(REG_SYNC_HIGH, 8'hFF);
          cfg_write(REG_SYNC_LOW, 8'h00);
          steady = 1'b1;
        end
        3: begin
          // equal sync bytes: the low match wins over the repeated high
          cfg_write(REG_SYNC_HIGH, 8'h5A);
          cfg_write(REG_SYNC_LOW, 8'h5A);
          steady = 1'b0;
        end
        4: begin
          cfg_write(REG_SYNC_HIGH, 8'($urandom_range(0, 255)));
          cfg_write(REG_SYNC_LOW, 8'($urandom_range(0, 255)));
          steady = 1'b1;
          hold_cycles = 100;
        end
        default: ;
      endcase
      run_random(PHASE_BUDGET);
      steady = 1'b0;
    end

    waited = 0;
    while (sb.pending.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending.size() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.pending.size()));
    end
    if (sb.errors == 0) begin
      $display("sync_length_frame_deframer_test: clean");
    end else begin
      $display("sync_length_frame_deframer_test: errors");
    end
    $finish;
  end

endmodule
